// ----- src/pcss_pkg.sv -----
// Package for the pipeline compute slot scheduler.
// Holds shared widths, reset values, register indexes, the state type and a width helper.
// No dependencies.
package pcss_pkg;

	localparam int MAX_STAGES_DEF  = 8;
	localparam int MAX_BATCHES_DEF = 32;

	localparam int TAG_W       = 5;
	localparam int STAGE_CFG_W = 4;
	localparam int BATCH_CFG_W = 6;
	localparam int CFG_DATA_W  = 6;
	localparam int CFG_IDX_W   = 1;
	localparam int COUNT_W     = 6;

	localparam logic [COUNT_W-1:0]     COUNT_MAX   = 6'd63;
	localparam logic [STAGE_CFG_W-1:0] STAGE_RESET = 4'd4;
	localparam logic [BATCH_CFG_W-1:0] BATCH_RESET = 6'd8;

	localparam logic [CFG_IDX_W-1:0] REG_STAGE_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_BATCH_COUNT = 1'b1;

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_SETUP  = 8'b0000_0010,
		ST_SRCH   = 8'b0000_0100,
		ST_FAIL   = 8'b0000_1000,
		ST_FIX    = 8'b0001_0000,
		ST_INC_RD = 8'b0010_0000,
		ST_INC_WR = 8'b0100_0000,
		ST_OUT    = 8'b1000_0000
	} state_t;

	function automatic int bits_for(int n);
		if (n <= 2) begin
			return 1;
		end
		return $clog2(n);
	endfunction

endpackage

// ----- src/pcss_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on pcss_pkg for the address width helper.
module pcss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [pcss_pkg::bits_for(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [pcss_pkg::bits_for(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);
	import pcss_pkg::*;

	localparam int AW = bits_for(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    unused_aw;

	assign unused_aw = raddr;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[unused_aw];
	end

endmodule

// ----- src/pipeline_compute_slot_scheduler.sv -----
// Top level of the pipeline compute slot scheduler: sequencer, slot search and result port.
// Depends on pcss_pkg and on pcss_ram, which holds the busy bits and in-flight count per slot.
//
//   channel  direction  handshake            payload
//   cfg      in         cfg_we               cfg_index, cfg_data
//   in       in         in_valid / in_stall  batch_label
//   out      out        out_valid / out_stall batch_tag, stage_index, forward_slot,
//                                            backward_slot, last
//
// One word is taken only while the block is idle; in_stall stays high until its last result leaves.
// Each stage search probes slots in order; a failed search goes through ST_FAIL and ST_FIX to slot 0.
// The in-flight update reads and writes each slot from stage 0's forward to backward slot in turn.
// Then one result word per cycle, held while out_stall is high.
// All work goes through the one read port of the slot RAM.
// Reset sets default configuration, clears per-slot valid bits and last forward slots; no clear pass.
module pipeline_compute_slot_scheduler #(
	parameter int MAX_STAGES  = pcss_pkg::MAX_STAGES_DEF,
	parameter int MAX_BATCHES = pcss_pkg::MAX_BATCHES_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [pcss_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [pcss_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [pcss_pkg::TAG_W-1:0]            batch_label,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [pcss_pkg::TAG_W-1:0]            batch_tag,
	output logic [pcss_pkg::bits_for(MAX_STAGES)-1:0] stage_index,
	output logic [pcss_pkg::bits_for(2*MAX_STAGES+2*(MAX_BATCHES-1))-1:0] forward_slot,
	output logic [pcss_pkg::bits_for(2*MAX_STAGES+2*(MAX_BATCHES-1))-1:0] backward_slot,
	output logic                                   last
);
	import pcss_pkg::*;

	localparam int TABLE_MAX = 2 * MAX_STAGES + 2 * (MAX_BATCHES - 1);
	localparam int IDX_W     = bits_for(MAX_STAGES);
	localparam int SLOT_W    = bits_for(TABLE_MAX);
	localparam int NS_W      = bits_for(MAX_STAGES + 1);
	localparam int NB_W      = bits_for(MAX_BATCHES + 1);
	localparam int T_W       = bits_for(TABLE_MAX + 3);
	localparam int ROW_W     = MAX_STAGES + COUNT_W;

	state_t                   state_q;
	logic [STAGE_CFG_W-1:0]   stage_cfg_q;
	logic [BATCH_CFG_W-1:0]   batch_cfg_q;
	logic [IDX_W-1:0]         stg_q;
	logic                     phase_bwd_q;
	logic                     first_q;
	logic                     pend_q;
	logic [T_W-1:0]           t_q;
	logic [T_W-1:0]           a_q;
	logic [SLOT_W-1:0]        last_q;
	logic [TAG_W-1:0]         tag_q;
	logic [SLOT_W-1:0]        prev_fwd_q [MAX_STAGES];
	logic [SLOT_W-1:0]        bwd_q [MAX_STAGES];
	logic [TABLE_MAX-1:0]     valid_q;

	logic [NS_W-1:0]          ns;
	logic [NB_W-1:0]          nb;
	logic [T_W-1:0]           len;
	logic [T_W-1:0]           start_t;
	logic                     is_last_stg;
	logic [ROW_W-1:0]         rd_data;
	logic [ROW_W-1:0]         row_eff;
	logic [MAX_STAGES-1:0]    row_busy;
	logic [COUNT_W-1:0]       row_cnt;
	logic [MAX_STAGES-1:0]    stage_bit;
	logic                     hit;
	logic                     commit;
	logic [SLOT_W-1:0]        commit_slot;
	logic                     ram_we;
	logic [SLOT_W-1:0]        ram_waddr;
	logic [ROW_W-1:0]         ram_wdata;
	logic [SLOT_W-1:0]        ram_raddr;

	always_comb begin
		if (stage_cfg_q == '0) begin
			ns = NS_W'(1);
		end else if (int'(stage_cfg_q) > MAX_STAGES) begin
			ns = NS_W'(MAX_STAGES);
		end else begin
			ns = NS_W'(stage_cfg_q);
		end
		if (batch_cfg_q == '0) begin
			nb = NB_W'(1);
		end else if (int'(batch_cfg_q) > MAX_BATCHES) begin
			nb = NB_W'(MAX_BATCHES);
		end else begin
			nb = NB_W'(batch_cfg_q);
		end
	end

	assign len         = T_W'(2 * int'(ns) + 2 * (int'(nb) - 1));
	assign start_t     = phase_bwd_q ? T_W'(prev_fwd_q[stg_q]) + T_W'(1)
	                                 : T_W'(prev_fwd_q[stg_q]);
	assign is_last_stg = (NS_W'(stg_q) + NS_W'(1)) == ns;
	assign row_eff     = valid_q[a_q[SLOT_W-1:0]] ? rd_data : '0;
	assign row_busy    = row_eff[ROW_W-1:COUNT_W];
	assign row_cnt     = row_eff[COUNT_W-1:0];
	assign stage_bit   = MAX_STAGES'(1) << stg_q;
	assign hit         = pend_q && !row_busy[stg_q] && (first_q || a_q > T_W'(last_q))
	                     && (row_cnt < COUNT_W'(ns));
	assign commit      = ((state_q == ST_SRCH) && hit) || (state_q == ST_FIX);
	assign commit_slot = a_q[SLOT_W-1:0];

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = a_q[SLOT_W-1:0];
		ram_wdata = row_eff;
		ram_raddr = '0;
		case (state_q)
			ST_SETUP: begin
				if (start_t < len) begin
					ram_raddr = start_t[SLOT_W-1:0];
				end
			end
			ST_SRCH: begin
				if (t_q < len) begin
					ram_raddr = t_q[SLOT_W-1:0];
				end
				if (hit) begin
					ram_we    = 1'b1;
					ram_wdata = {row_busy | stage_bit, row_cnt};
				end
			end
			ST_FIX: begin
				ram_we    = 1'b1;
				ram_wdata = {row_busy | stage_bit, row_cnt};
			end
			ST_INC_RD: begin
				ram_raddr = t_q[SLOT_W-1:0];
			end
			ST_INC_WR: begin
				ram_we    = 1'b1;
				ram_wdata = {row_busy, (row_cnt == COUNT_MAX) ? row_cnt : row_cnt + COUNT_W'(1)};
			end
			default: begin
			end
		endcase
	end

	pcss_ram #(
		.WIDTH (ROW_W),
		.DEPTH (TABLE_MAX)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			stage_cfg_q <= STAGE_RESET;
			batch_cfg_q <= BATCH_RESET;
			stg_q       <= '0;
			phase_bwd_q <= 1'b0;
			first_q     <= 1'b1;
			pend_q      <= 1'b0;
			t_q         <= '0;
			a_q         <= '0;
			last_q      <= '0;
			valid_q     <= '0;
			for (int i = 0; i < MAX_STAGES; i++) begin
				prev_fwd_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_STAGE_COUNT: stage_cfg_q <= cfg_data[STAGE_CFG_W-1:0];
					REG_BATCH_COUNT: batch_cfg_q <= cfg_data[BATCH_CFG_W-1:0];
					default: begin
					end
				endcase
			end
			if (ram_we) begin
				valid_q[ram_waddr] <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						stg_q       <= '0;
						phase_bwd_q <= 1'b0;
						first_q     <= 1'b1;
						state_q     <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					a_q     <= start_t;
					pend_q  <= start_t < len;
					t_q     <= start_t + T_W'(1);
					state_q <= ST_SRCH;
				end
				ST_SRCH: begin
					if (!hit) begin
						if (!pend_q) begin
							a_q     <= '0;
							state_q <= ST_FAIL;
						end else begin
							a_q    <= t_q;
							pend_q <= t_q < len;
							t_q    <= t_q + T_W'(1);
						end
					end
				end
				ST_FAIL: begin
					state_q <= ST_FIX;
				end
				ST_FIX: begin
				end
				ST_INC_RD: begin
					a_q     <= t_q;
					state_q <= ST_INC_WR;
				end
				ST_INC_WR: begin
					t_q <= t_q + T_W'(1);
					if (a_q < T_W'(last_q)) begin
						state_q <= ST_INC_RD;
					end else begin
						stg_q   <= '0;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out_stall) begin
						if (is_last_stg) begin
							state_q <= ST_IDLE;
						end else begin
							stg_q <= stg_q + IDX_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (commit) begin
				last_q  <= commit_slot;
				first_q <= !phase_bwd_q && is_last_stg;
				if (!phase_bwd_q) begin
					prev_fwd_q[stg_q] <= commit_slot;
					state_q           <= ST_SETUP;
					if (is_last_stg) begin
						phase_bwd_q <= 1'b1;
						stg_q       <= IDX_W'(ns - NS_W'(1));
					end else begin
						stg_q <= stg_q + IDX_W'(1);
					end
				end else if (stg_q == '0) begin
					t_q <= T_W'(prev_fwd_q[0]);
					if (prev_fwd_q[0] <= commit_slot) begin
						state_q <= ST_INC_RD;
					end else begin
						state_q <= ST_OUT;
					end
				end else begin
					stg_q   <= stg_q - IDX_W'(1);
					state_q <= ST_SETUP;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && in_valid) begin
			tag_q <= batch_label;
		end
		if (commit && phase_bwd_q) begin
			bwd_q[stg_q] <= commit_slot;
		end
	end

	assign in_stall      = state_q != ST_IDLE;
	assign out_valid     = state_q == ST_OUT;
	assign batch_tag     = tag_q;
	assign stage_index   = stg_q;
	assign forward_slot  = prev_fwd_q[stg_q];
	assign backward_slot = bwd_q[stg_q];
	assign last          = is_last_stg;

`ifndef SYNTHESIS
	// A result word always names a configured stage.
	a_out_stage: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (NS_W'(stg_q) < ns))
		else $error("result word for a stage beyond the configured count");

	// The block never offers results while it is free to take a new word.
	a_idle_no_out: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !out_valid)
		else $error("result offered while idle");

	// A backward slot found by search lies after the forward slot of its stage.
	a_bwd_after_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && phase_bwd_q && (state_q == ST_SRCH))
		|-> (T_W'(commit_slot) > T_W'(prev_fwd_q[stg_q])))
		else $error("backward slot not after forward slot");

	// Every table update stays inside the current table length.
	a_write_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (T_W'(ram_waddr) < len))
		else $error("slot table write beyond table length");
`endif

endmodule
